@@ rtl/tsxp_pkg.sv @@
// Shared types and codes for the ServerKeyExchange body parser.
package tsxp_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned WordWidth  = 16;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned KindWidth  = 3;
   localparam int unsigned StatWidth  = 3;

   localparam logic [ByteWidth-1:0] NAMED_CURVE_TYPE = 8'd3;

   // Parser phases
   localparam logic [PhaseWidth-1:0] PH_CTYPE = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_CURVE = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_KLEN  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_KEY   = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_ALG   = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_SLEN  = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_SIG   = 3'd6;
   localparam logic [PhaseWidth-1:0] PH_DONE  = 3'd7;

   // Field tags on the result
   localparam logic [KindWidth-1:0] KIND_CTYPE   = 3'd0;
   localparam logic [KindWidth-1:0] KIND_CURVE   = 3'd1;
   localparam logic [KindWidth-1:0] KIND_KLEN    = 3'd2;
   localparam logic [KindWidth-1:0] KIND_KEY     = 3'd3;
   localparam logic [KindWidth-1:0] KIND_ALG     = 3'd4;
   localparam logic [KindWidth-1:0] KIND_SLEN    = 3'd5;
   localparam logic [KindWidth-1:0] KIND_SIG     = 3'd6;
   localparam logic [KindWidth-1:0] KIND_IGNORED = 3'd7;

   // Status codes
   localparam logic [StatWidth-1:0] ST_OK         = 3'd0;
   localparam logic [StatWidth-1:0] ST_BAD_CTYPE  = 3'd1;
   localparam logic [StatWidth-1:0] ST_ZERO_KLEN  = 3'd2;
   localparam logic [StatWidth-1:0] ST_ZERO_SLEN  = 3'd3;
   localparam logic [StatWidth-1:0] ST_BODY_SHORT = 3'd4;
   localparam logic [StatWidth-1:0] ST_BODY_LONG  = 3'd5;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [WordWidth-1:0]  bytes_left;
      logic [StatWidth-1:0]  error_code;
      logic [WordWidth-1:0]  curve;
      logic [WordWidth-1:0]  scheme;
      logic [ByteWidth-1:0]  key_len;
      logic [WordWidth-1:0]  sig_len;
   } parse_state_type;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_out;
      logic [KindWidth-1:0] field_kind;
      logic                 done_res;
      logic [StatWidth-1:0] status;
      logic [WordWidth-1:0] curve_id;
      logic [WordWidth-1:0] signature_scheme;
      logic [ByteWidth-1:0] key_length;
      logic [WordWidth-1:0] signature_length;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:      PH_CTYPE,
      bytes_left: '0,
      error_code: ST_OK,
      curve:      '0,
      scheme:     '0,
      key_len:    '0,
      sig_len:    '0
   };

endpackage

@@ rtl/tsxp_step.sv @@
// Per-byte parse step: next parser state and the tagged result for one request.
module tsxp_step
   import tsxp_pkg::*;
(
   input  parse_state_type      state_cur,
   input  logic [ByteWidth-1:0] body_byte,
   input  logic                 body_last,
   output parse_state_type      state_nxt,
   output result_type           result
);

   parse_state_type      upd;
   logic [KindWidth-1:0] kind;
   logic [WordWidth-1:0] left_dec;
   logic [WordWidth-1:0] slen_new;

   assign left_dec = state_cur.bytes_left - WordWidth'(1);
   assign slen_new = {state_cur.sig_len[ByteWidth-1:0], body_byte};

   always_comb begin
      upd  = state_cur;
      kind = KIND_IGNORED;
      if (state_cur.error_code == ST_OK) begin
         kind = state_cur.phase;
         unique case (state_cur.phase)
            PH_CTYPE: begin
               if (body_byte != NAMED_CURVE_TYPE) begin
                  upd.error_code = ST_BAD_CTYPE;
               end else begin
                  upd.phase      = PH_CURVE;
                  upd.bytes_left = WordWidth'(2);
               end
            end
            PH_CURVE: begin
               upd.curve      = {state_cur.curve[ByteWidth-1:0], body_byte};
               upd.bytes_left = left_dec;
               if (left_dec == '0) upd.phase = PH_KLEN;
            end
            PH_KLEN: begin
               upd.key_len = body_byte;
               if (body_byte == '0) begin
                  upd.error_code = ST_ZERO_KLEN;
               end else begin
                  upd.phase      = PH_KEY;
                  upd.bytes_left = WordWidth'(body_byte);
               end
            end
            PH_KEY: begin
               upd.bytes_left = left_dec;
               if (left_dec == '0) begin
                  upd.phase      = PH_ALG;
                  upd.bytes_left = WordWidth'(2);
               end
            end
            PH_ALG: begin
               upd.scheme     = {state_cur.scheme[ByteWidth-1:0], body_byte};
               upd.bytes_left = left_dec;
               if (left_dec == '0) begin
                  upd.phase      = PH_SLEN;
                  upd.bytes_left = WordWidth'(2);
               end
            end
            PH_SLEN: begin
               upd.sig_len    = slen_new;
               upd.bytes_left = left_dec;
               if (left_dec == '0) begin
                  if (slen_new == '0) begin
                     upd.error_code = ST_ZERO_SLEN;
                  end else begin
                     upd.phase      = PH_SIG;
                     upd.bytes_left = slen_new;
                  end
               end
            end
            PH_SIG: begin
               upd.bytes_left = left_dec;
               if (left_dec == '0) upd.phase = PH_DONE;
            end
            PH_DONE: begin
               // trailing byte after a complete body
               upd.error_code = ST_BODY_LONG;
               kind           = KIND_IGNORED;
            end
            default: begin
               upd.error_code = ST_BODY_LONG;
               kind           = KIND_IGNORED;
            end
         endcase
      end
      if (body_last && upd.error_code == ST_OK && upd.phase != PH_DONE) begin
         upd.error_code = ST_BODY_SHORT;
      end
   end

   assign result = '{
      byte_out:         body_byte,
      field_kind:       kind,
      done_res:         body_last,
      status:           upd.error_code,
      curve_id:         upd.curve,
      signature_scheme: upd.scheme,
      key_length:       upd.key_len,
      signature_length: upd.sig_len
   };

   // return to the reset state once the body ends
   assign state_nxt = body_last ? STATE_RESET : upd;

endmodule

@@ rtl/tls12_server_key_exchange_parser_unit.sv @@
// Top level of the ServerKeyExchange body parser: request register, parse step, result register.
//
//   channel | ports  | carries
//   --------+--------+------------------------------------------------
//   input   | req_*  | one body byte and its last-byte flag
//   output  | rsp_*  | byte, field tag, status and parsed header fields
//
// One request a cycle is sustained while rsp_ready is high; each result follows the request register.
// The parse state register closes the only loop, one short step per byte.
// Reset clears the request and result valids and the parse state; no clearing pass.
// A stalled result holds the request register; both stages fill before req_ready drops.
module tls12_server_key_exchange_parser_unit
   import tsxp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_body_byte,
   input  logic                 req_body_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ByteWidth-1:0] rsp_byte_out,
   output logic [KindWidth-1:0] rsp_field_kind,
   output logic                 rsp_done_res,
   output logic [StatWidth-1:0] rsp_status,
   output logic [WordWidth-1:0] rsp_curve_id,
   output logic [WordWidth-1:0] rsp_signature_scheme,
   output logic [ByteWidth-1:0] rsp_key_length,
   output logic [WordWidth-1:0] rsp_signature_length
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   parse_state_type      state_ff;
   parse_state_type      state_in;
   result_type           res_ff;
   result_type           res_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 advance;
   logic                 req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   tsxp_step u_step (
      .state_cur (state_ff),
      .body_byte (in_byte_ff),
      .body_last (in_last_ff),
      .state_nxt (state_in),
      .result    (res_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_body_byte;
         in_last_ff <= req_body_last;
      end
      if (advance) res_ff <= res_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_byte_out         = res_ff.byte_out;
   assign rsp_field_kind       = res_ff.field_kind;
   assign rsp_done_res         = res_ff.done_res;
   assign rsp_status           = res_ff.status;
   assign rsp_curve_id         = res_ff.curve_id;
   assign rsp_signature_scheme = res_ff.signature_scheme;
   assign rsp_key_length       = res_ff.key_length;
   assign rsp_signature_length = res_ff.signature_length;

`ifndef SYNTHESIS
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == STATE_RESET)
      else $error("parse state not restored after last byte");

   a_error_freezes_state: assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff && state_ff.error_code != ST_OK |=> $stable(state_ff))
      else $error("state moved after a latched error");

   a_short_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status != ST_BODY_SHORT)
      else $error("body short reported before the last byte");

   a_ignored_has_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind == KIND_IGNORED |-> rsp_status != ST_OK)
      else $error("ignored byte without an error status");
`endif

endmodule
